[rtl/core/mods_pkg.sv]
// Shared constants and ROM content functions for the morphing oscillator and diode shaper.
`timescale 1ns / 1ps

package mods_pkg;

  // Default table depths and wave count.
  localparam int COSINE_TABLE_DEPTH = 1024;
  localparam int EXP_TABLE_DEPTH    = 256;
  localparam int WAVE_COUNT         = 4;

  // Control range in Q.11, and fixed multipliers.
  localparam int CTRL_MAX  = 20480;
  // 3.999/20 in Q.21.
  localparam int MORPH_K   = 419326;
  // ceil(2^21/5): exact floor division by five for dividends below 2^19.
  localparam int MIX_RECIP = 419431;

  // Q30 constants used to build the ROM contents.
  localparam longint ONE_Q30         = 64'sd1073741824;
  localparam longint HALF_PI_Q30     = 64'sd1686629713;
  localparam longint DIODE_EXP_Q30   = 64'sd2526213589;
  localparam longint DIODE_SCALE_Q30 = 64'sd112742892;

  // Wave select codes.
  localparam logic [1:0] WAVE_COS = 2'd0;
  localparam logic [1:0] WAVE_SQR = 2'd1;
  localparam logic [1:0] WAVE_SAW = 2'd2;
  localparam logic [1:0] WAVE_TRI = 2'd3;

  // Q15 sample with room for +1.0.
  typedef logic signed [16:0] q15_t;

  // Quotient truncated toward zero, by shift and subtract, for building table contents.
  function automatic longint div_trunc(input longint n, input longint d);
    longint unsigned un;
    longint unsigned ud;
    longint unsigned qt;
    longint unsigned rm;
    un = $unsigned((n < 0) ? -n : n);
    ud = $unsigned((d < 0) ? -d : d);
    qt = '0;
    rm = '0;
    for (int b = 63; b >= 0; b--) begin
      rm = {rm[62:0], un[b]};
      if (rm >= ud) begin
        rm    = rm - ud;
        qt[b] = 1'b1;
      end
    end
    return ((n < 0) != (d < 0)) ? -$signed(qt) : $signed(qt);
  endfunction

  // Q30 product, truncated toward zero.
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b) / ONE_Q30;
  endfunction

  // Q30 to Q15, rounding half away from zero.
  function automatic int q30_to_q15(input longint v);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m + 64'sd16384) >>> 15;
    return int'((v < 0) ? -r : r);
  endfunction

  // One cosine ROM entry over a full period of the given depth.
  function automatic int cos_entry(input int idx, input int depth);
    longint cden [7];
    longint sden [6];
    longint t;
    longint a;
    longint x;
    longint c;
    longint s;
    longint v;
    int     q;
    cden = '{64'sd182, 64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};
    sden = '{64'sd156, 64'sd110, 64'sd72, 64'sd42, 64'sd20, 64'sd6};
    t = div_trunc(longint'(idx) <<< 32, longint'(depth));
    q = int'((t >>> 30) & 64'sd3);
    a = ((t & 64'sh3FFF_FFFF) * HALF_PI_Q30) >>> 30;
    x = mul_q30(a, a);
    c = ONE_Q30;
    s = ONE_Q30;
    for (int k = 0; k < 7; k++) begin
      c = ONE_Q30 - div_trunc(mul_q30(x, c), cden[k]);
    end
    for (int k = 0; k < 6; k++) begin
      s = ONE_Q30 - div_trunc(mul_q30(x, s), sden[k]);
    end
    s = mul_q30(a, s);
    if (c < 0) c = 0;
    if (s < 0) s = 0;
    case (q)
      0:       v = c;
      1:       v = -s;
      2:       v = -c;
      default: v = s;
    endcase
    return q30_to_q15(v);
  endfunction

  // One diode curve entry over v = -1..1, both ends included.
  // The exponential runs unsigned: its square at the top end passes 2^63.
  function automatic int diode_entry(input int idx, input int depth);
    longint          num;
    longint          z;
    longint unsigned az;
    longint unsigned r;
    num = 2 * longint'(idx) - longint'(depth - 1);
    z   = div_trunc(DIODE_EXP_Q30 * num, longint'(depth - 1));
    az  = $unsigned(((z < 0) ? -z : z) / 64'sd4);
    r   = $unsigned(ONE_Q30);
    for (int k = 14; k >= 1; k--) begin
      r = $unsigned(ONE_Q30 + div_trunc(longint'((az * r) >> 30), longint'(k)));
    end
    r = (r * r) >> 30;
    r = (r * r) >> 30;
    if (z < 0) r = $unsigned(div_trunc(64'sd1 <<< 60, longint'(r)));
    return q30_to_q15(((longint'(r) - ONE_Q30) * DIODE_SCALE_Q30) / ONE_Q30);
  endfunction

endpackage

[rtl/core/morphing_oscillator_diode_shaper.sv]
// Morphing four-wave oscillator with diode waveshaper, nine-stage pipeline.
//
//   Channel | Ports                                            | Dir
//   --------+--------------------------------------------------+----
//   input   | in_valid, in_stall, in_phase, in_morph_control,  | in
//           | in_mix_control                                   |
//   result  | out_valid, out_stall, out_sample                 | out
//
// One beat enters per clock while in_stall is low, and its sample leaves through the nine registered stages.
// The depth is set by two registered ROM reads, three interpolations and the mix.
// Synchronous active-low reset clears the stage valid bits only.
// A stall holds a full stage only while every stage ahead of it is full; bubbles are squeezed out.
`timescale 1ns / 1ps

module morphing_oscillator_diode_shaper
  import mods_pkg::*;
#(
  parameter int COS_DEPTH = COSINE_TABLE_DEPTH,
  parameter int EXP_DEPTH = EXP_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [15:0] in_phase,
  input  logic signed [15:0] in_morph_control,
  input  logic signed [15:0] in_mix_control,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample
);

  localparam int NSTG   = 9;
  localparam int CIDX_W = $clog2(COS_DEPTH);
  localparam int CPOS_W = 16 + $clog2(COS_DEPTH + 1);
  localparam int EIDX_W = $clog2(EXP_DEPTH);
  localparam int DPOS_W = 17 + EIDX_W;

  // Constant ROM contents.
  q15_t cos_tab   [COS_DEPTH];
  q15_t diode_tab [EXP_DEPTH];

  for (genvar gi = 0; gi < COS_DEPTH; gi++) begin : g_cos
    localparam q15_t CVAL = 17'(cos_entry(gi, COS_DEPTH));
    assign cos_tab[gi] = CVAL;
  end

  for (genvar gi = 0; gi < EXP_DEPTH; gi++) begin : g_diode
    localparam q15_t DVAL = 17'(diode_entry(gi, EXP_DEPTH));
    assign diode_tab[gi] = DVAL;
  end

  // Pipeline flow control: a stage moves when it is empty or its successor moves.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 0: saturate controls, morph position, mix factor and cosine address.
  logic signed [15:0] morph_sat;
  logic signed [15:0] mix_sat;
  logic        [15:0] morph_u;
  logic        [15:0] mix_u;
  logic        [34:0] morph_prod;
  logic        [18:0] mix_n;
  logic        [39:0] mix_prod;
  logic [CPOS_W-1:0]  cpos;

  always_comb begin
    if (in_morph_control > 16'(CTRL_MAX))       morph_sat = 16'(CTRL_MAX);
    else if (in_morph_control < -16'(CTRL_MAX)) morph_sat = -16'(CTRL_MAX);
    else                                        morph_sat = in_morph_control;
    if (in_mix_control > 16'(CTRL_MAX))         mix_sat = 16'(CTRL_MAX);
    else if (in_mix_control < -16'(CTRL_MAX))   mix_sat = -16'(CTRL_MAX);
    else                                        mix_sat = in_mix_control;
    morph_u    = 16'($signed({morph_sat[15], morph_sat}) + 17'(CTRL_MAX));
    mix_u      = 16'($signed({mix_sat[15], mix_sat}) + 17'(CTRL_MAX));
    morph_prod = 35'(morph_u) * 35'(MORPH_K);
    mix_n      = {mix_u, 3'b000} + 19'd2;
    mix_prod   = 40'(mix_n) * 40'(MIX_RECIP);
    cpos       = CPOS_W'(in_phase) * CPOS_W'(COS_DEPTH);
  end

  logic        [15:0] p0_r;
  logic        [1:0]  sel0_r;
  logic        [15:0] fm0_r;
  logic        [16:0] mf0_r;
  logic [CIDX_W-1:0]  cidx0_r;
  logic        [15:0] cfr0_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p0_r    <= in_phase;
      sel0_r  <= morph_prod[33:32];
      fm0_r   <= morph_prod[31:16];
      mf0_r   <= mix_prod[37:21];
      cidx0_r <= cpos[16 +: CIDX_W];
      cfr0_r  <= cpos[15:0];
    end
  end

  // Stage 1: cosine ROM reads and the three geometric waves.
  logic [CIDX_W-1:0]  cidx_nx;
  logic signed [17:0] tri_d;
  logic signed [17:0] tri_abs;
  q15_t               sq_nxt;
  q15_t               saw_nxt;
  q15_t               tri_nxt;

  always_comb begin
    cidx_nx = (cidx0_r == CIDX_W'(COS_DEPTH - 1)) ? '0 : cidx0_r + CIDX_W'(1);
    sq_nxt  = p0_r[15] ? 17'sd32768 : -17'sd32768;
    saw_nxt = $signed({1'b0, p0_r}) - 17'sd32768;
    tri_d   = $signed({1'b0, p0_r, 1'b0}) - 18'sd65536;
    tri_abs = (tri_d < 0) ? -tri_d : tri_d;
    tri_nxt = 17'(18'sd32768 - tri_abs);
  end

  q15_t        ca1_r;
  q15_t        cb1_r;
  q15_t        sq1_r;
  q15_t        saw1_r;
  q15_t        tri1_r;
  logic [1:0]  sel1_r;
  logic [15:0] fm1_r;
  logic [16:0] mf1_r;
  logic [15:0] cfr1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ca1_r  <= cos_tab[cidx0_r];
      cb1_r  <= cos_tab[cidx_nx];
      sq1_r  <= sq_nxt;
      saw1_r <= saw_nxt;
      tri1_r <= tri_nxt;
      sel1_r <= sel0_r;
      fm1_r  <= fm0_r;
      mf1_r  <= mf0_r;
      cfr1_r <= cfr0_r;
    end
  end

  // Stage 2: cosine interpolation, negated.
  logic signed [17:0] cw_a;
  logic signed [17:0] cw_b;
  logic signed [35:0] cp_a;
  logic signed [35:0] cp_b;
  logic signed [35:0] cacc;
  logic signed [35:0] csh;
  q15_t               cneg_nxt;

  always_comb begin
    cw_a     = 18'sd65536 - $signed({2'b00, cfr1_r});
    cw_b     = $signed({2'b00, cfr1_r});
    cp_a     = cw_a * ca1_r;
    cp_b     = cw_b * cb1_r;
    cacc     = cp_a + cp_b + 36'sd32768;
    csh      = cacc >>> 16;
    cneg_nxt = 17'(-csh);
  end

  q15_t        cos2_r;
  q15_t        sq2_r;
  q15_t        saw2_r;
  q15_t        tri2_r;
  logic [1:0]  sel2_r;
  logic [15:0] fm2_r;
  logic [16:0] mf2_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cos2_r <= cneg_nxt;
      sq2_r  <= sq1_r;
      saw2_r <= saw1_r;
      tri2_r <= tri1_r;
      sel2_r <= sel1_r;
      fm2_r  <= fm1_r;
      mf2_r  <= mf1_r;
    end
  end

  // Stage 3: pick the two neighboring waves and blend them by the morph fraction.
  logic [1:0]         sel_b;
  q15_t               wa;
  q15_t               wb;
  logic signed [17:0] fw_a;
  logic signed [17:0] fw_b;
  logic signed [35:0] wp_a;
  logic signed [35:0] wp_b;
  logic signed [35:0] wacc;
  logic signed [35:0] wsh;
  q15_t               w_nxt;

  always_comb begin
    sel_b = sel2_r + 2'd1;
    case (sel2_r)
      WAVE_COS: wa = cos2_r;
      WAVE_SQR: wa = sq2_r;
      WAVE_SAW: wa = saw2_r;
      WAVE_TRI: wa = tri2_r;
      default:  wa = cos2_r;
    endcase
    case (sel_b)
      WAVE_COS: wb = cos2_r;
      WAVE_SQR: wb = sq2_r;
      WAVE_SAW: wb = saw2_r;
      WAVE_TRI: wb = tri2_r;
      default:  wb = cos2_r;
    endcase
    fw_a  = 18'sd65536 - $signed({2'b00, fm2_r});
    fw_b  = $signed({2'b00, fm2_r});
    wp_a  = fw_a * wa;
    wp_b  = fw_b * wb;
    wacc  = wp_a + wp_b + 36'sd32768;
    wsh   = wacc >>> 16;
    w_nxt = 17'(wsh);
  end

  q15_t        w3_r;
  logic [16:0] mf3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      w3_r  <= w_nxt;
      mf3_r <= mf2_r;
    end
  end

  // Stage 4: diode table address and fraction; the top end reads the last entry twice.
  q15_t               w_clip;
  logic        [16:0] w_off;
  logic [DPOS_W-1:0]  dpos;
  logic [EIDX_W-1:0]  didx;
  logic               dtop;
  logic [EIDX_W-1:0]  da_nxt;
  logic [EIDX_W-1:0]  db_nxt;

  always_comb begin
    if (w3_r > 17'sd32768)       w_clip = 17'sd32768;
    else if (w3_r < -17'sd32768) w_clip = -17'sd32768;
    else                         w_clip = w3_r;
    w_off  = 17'($signed({w_clip[16], w_clip}) + 18'sd32768);
    dpos   = DPOS_W'(w_off) * DPOS_W'(EXP_DEPTH - 1);
    didx   = dpos[16 +: EIDX_W];
    dtop   = (didx >= EIDX_W'(EXP_DEPTH - 1));
    da_nxt = dtop ? EIDX_W'(EXP_DEPTH - 1) : didx;
    db_nxt = dtop ? EIDX_W'(EXP_DEPTH - 1) : didx + EIDX_W'(1);
  end

  logic [EIDX_W-1:0] da4_r;
  logic [EIDX_W-1:0] db4_r;
  logic [15:0]       dfr4_r;
  q15_t              w4_r;
  logic [16:0]       mf4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      da4_r  <= da_nxt;
      db4_r  <= db_nxt;
      dfr4_r <= dpos[15:0];
      w4_r   <= w_clip;
      mf4_r  <= mf3_r;
    end
  end

  // Stage 5: diode ROM reads.
  q15_t        dva5_r;
  q15_t        dvb5_r;
  logic [15:0] dfr5_r;
  q15_t        w5_r;
  logic [16:0] mf5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dva5_r <= diode_tab[da4_r];
      dvb5_r <= diode_tab[db4_r];
      dfr5_r <= dfr4_r;
      w5_r   <= w4_r;
      mf5_r  <= mf4_r;
    end
  end

  // Stage 6: diode curve interpolation.
  logic signed [17:0] df_a;
  logic signed [17:0] df_b;
  logic signed [35:0] dp_a;
  logic signed [35:0] dp_b;
  logic signed [35:0] dacc;
  logic signed [35:0] dsh;
  q15_t               d_nxt;

  always_comb begin
    df_a  = 18'sd65536 - $signed({2'b00, dfr5_r});
    df_b  = $signed({2'b00, dfr5_r});
    dp_a  = df_a * dva5_r;
    dp_b  = df_b * dvb5_r;
    dacc  = dp_a + dp_b + 36'sd32768;
    dsh   = dacc >>> 16;
    d_nxt = 17'(dsh);
  end

  q15_t        d6_r;
  q15_t        w6_r;
  logic [16:0] mf6_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      d6_r  <= d_nxt;
      w6_r  <= w5_r;
      mf6_r <= mf5_r;
    end
  end

  // Stage 7: dry and diode mix.
  logic signed [17:0] mx_a;
  logic signed [17:0] mx_b;
  logic signed [35:0] mp_a;
  logic signed [35:0] mp_b;
  logic signed [35:0] macc_nxt;

  always_comb begin
    mx_a     = 18'sd65536 - $signed({1'b0, mf6_r});
    mx_b     = $signed({1'b0, mf6_r});
    mp_a     = mx_a * w6_r;
    mp_b     = mx_b * d6_r;
    macc_nxt = mp_a + mp_b;
  end

  logic signed [35:0] macc7_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      macc7_r <= macc_nxt;
    end
  end

  // Stage 8: scale by ten, round to Q.11 and saturate.
  logic signed [39:0] mx40;
  logic signed [39:0] scaled;
  logic signed [39:0] ysh;
  logic signed [15:0] y_nxt;

  always_comb begin
    mx40   = 40'(macc7_r);
    scaled = (mx40 <<< 3) + (mx40 <<< 1) + 40'sd524288;
    ysh    = scaled >>> 20;
    if (ysh > 40'(CTRL_MAX))       y_nxt = 16'(CTRL_MAX);
    else if (ysh < -40'(CTRL_MAX)) y_nxt = -16'(CTRL_MAX);
    else                           y_nxt = 16'(ysh);
  end

  logic signed [15:0] y8_r;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      y8_r <= y_nxt;
    end
  end

  assign out_sample = y8_r;

endmodule

[tb/morphing_oscillator_diode_shaper_tb.sv]
// Self-checking testbench for the morphing oscillator and diode shaper.
`timescale 1ns / 1ps

module morphing_oscillator_diode_shaper_tb;
  import mods_pkg::*;

  localparam int     COS_N       = COSINE_TABLE_DEPTH;
  localparam int     EXP_N       = EXP_TABLE_DEPTH;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint DIODE_K_Q30 = 64'sd2526213589;
  localparam longint DIODE_I_Q30 = 64'sd112742892;
  localparam longint CTRL_LIM    = 64'sd20480;
  localparam longint LOW16       = 64'shFFFF;
  localparam int     N_RANDOM    = 1730;
  localparam int     PAUSE_A     = 18;
  localparam int     PAUSE_B     = 900;
  localparam int     QUIET_LIMIT = 2000;
  localparam int     TAIL_CYCLES = 30;

  typedef struct packed {
    logic        [15:0] phase;
    logic signed [15:0] morph;
    logic signed [15:0] mix;
  } osc_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [15:0] in_phase = '0;
  logic signed [15:0] in_morph_control = '0;
  logic signed [15:0] in_mix_control = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;

  osc_beat_t          stim_q[$];
  logic signed [15:0] exp_samples[$];
  int                 cos_lut[COS_N];
  int                 diode_lut[EXP_N];
  int                 in_count = 0;
  int                 out_count = 0;
  int                 n_total = 0;
  int                 errors = 0;
  logic               idle_ok;

  morphing_oscillator_diode_shaper #(
    .COS_DEPTH(COS_N),
    .EXP_DEPTH(EXP_N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_phase(in_phase),
    .in_morph_control(in_morph_control),
    .in_mix_control(in_mix_control),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample(out_sample)
  );

  // Idling is allowed except in every fourth window and near the end of the run.
  assign idle_ok = (in_count < n_total - 150) && ((in_count / 100) % 4 != 3);

  initial begin
    forever #5 clk = ~clk;
  end

  // Q30 product, truncated toward zero.
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) / Q30_ONE;
  endfunction

  // Q30 to Q15 with halves rounded away from zero.
  function automatic int q30_round_q15(longint v);
    longint m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m + 64'sd16384) >>> 15;
    return int'((v < 0) ? -r : r);
  endfunction

  // Floor of v / 2^s after adding half an LSB.
  function automatic longint round_down_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_ctrl(longint v);
    if (v > CTRL_LIM) return CTRL_LIM;
    if (v < -CTRL_LIM) return -CTRL_LIM;
    return v;
  endfunction

  // Cosine table word: series for sine and cosine on one quadrant, then folded.
  function automatic int cosine_word(int i);
    longint cden[7];
    longint sden[6];
    longint t;
    longint a;
    longint x;
    longint c;
    longint s;
    longint v;
    int     quad;
    cden = '{64'sd182, 64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};
    sden = '{64'sd156, 64'sd110, 64'sd72, 64'sd42, 64'sd20, 64'sd6};
    t = (longint'(i) <<< 32) / longint'(COS_N);
    quad = int'((t >>> 30) & 64'sd3);
    a = ((t & 64'sh3FFF_FFFF) * HALF_PI_Q30) >>> 30;
    x = q30_mul(a, a);
    c = Q30_ONE;
    s = Q30_ONE;
    for (int k = 0; k < 7; k++) c = Q30_ONE - q30_mul(x, c) / cden[k];
    for (int k = 0; k < 6; k++) s = Q30_ONE - q30_mul(x, s) / sden[k];
    s = q30_mul(a, s);
    if (c < 0) c = 0;
    if (s < 0) s = 0;
    case (quad)
      0: v = c;
      1: v = -s;
      2: v = -c;
      default: v = s;
    endcase
    return q30_round_q15(v);
  endfunction

  // Diode current word: exp by series on a quarter of the argument, squared twice.
  function automatic int diode_word(int i);
    longint          num;
    longint          z;
    longint          ex;
    longint unsigned az;
    longint unsigned r;
    num = 2 * longint'(i) - longint'(EXP_N - 1);
    z = (DIODE_K_Q30 * num) / longint'(EXP_N - 1);
    az = ((z < 0) ? -z : z) / 4;
    r = Q30_ONE;
    for (int k = 14; k >= 1; k--) r = Q30_ONE + ((az * r) >> 30) / longint'(k);
    r = (r * r) >> 30;
    r = (r * r) >> 30;
    if (z < 0) r = (64'd1 << 60) / r;
    ex = longint'(r);
    return q30_round_q15(((ex - Q30_ONE) * DIODE_I_Q30) / Q30_ONE);
  endfunction

  // One of the four basic waves in Q.15 at the given phase.
  function automatic longint wave_at(logic [1:0] sel, longint p);
    longint pos;
    longint f;
    longint idx;
    longint nx;
    longint d;
    case (sel)
      WAVE_COS: begin
        pos = p * COS_N;
        idx = pos >>> 16;
        f = pos & LOW16;
        nx = (idx + 1 >= COS_N) ? 0 : idx + 1;
        return -round_down_shift((65536 - f) * cos_lut[idx] + f * cos_lut[nx], 16);
      end
      WAVE_SQR: return (p >= 32768) ? 64'sd32768 : -64'sd32768;
      WAVE_SAW: return p - 32768;
      default: begin
        d = 2 * p - 65536;
        return 32768 - ((d < 0) ? -d : d);
      end
    endcase
  endfunction

  // Expected output sample for one input beat.
  function automatic logic signed [15:0] shaped_sample(logic [15:0] ph,
                                                       logic signed [15:0] morph_in,
                                                       logic signed [15:0] mix_in);
    longint     p;
    longint     morph;
    longint     mix;
    longint     pos;
    longint     f;
    longint     w;
    longint     dpos;
    longint     didx;
    longint     df;
    longint     d;
    longint     mf;
    longint     y;
    logic [1:0] sel;
    p = longint'(ph);
    morph = clamp_ctrl(longint'(morph_in));
    mix = clamp_ctrl(longint'(mix_in));

    // Morph position picks a pair of neighboring waves and a blend fraction.
    pos = ((morph + CTRL_LIM) * 64'sd419326) >>> 16;
    sel = 2'(pos >>> 16);
    f = pos & LOW16;
    w = round_down_shift((65536 - f) * wave_at(sel, p) + f * wave_at(sel + 2'd1, p), 16);

    // Diode curve lookup with interpolation; the top entry stands alone.
    if (w > 32768) w = 32768;
    if (w < -32768) w = -32768;
    dpos = (w + 32768) * (EXP_N - 1);
    didx = dpos >>> 16;
    if (didx >= EXP_N - 1) begin
      d = diode_lut[EXP_N - 1];
    end else begin
      df = dpos & LOW16;
      d = round_down_shift((65536 - df) * diode_lut[didx] + df * diode_lut[didx + 1], 16);
    end

    // Dry and shaped mix, scaled by ten.
    mf = ((mix + CTRL_LIM) * 8 + 2) / 5;
    y = round_down_shift(((65536 - mf) * w + mf * d) * 10, 20);
    return 16'(clamp_ctrl(y));
  endfunction

  // Random control value: mostly in range, sometimes extreme, sometimes any 16 bits.
  function automatic logic signed [15:0] pick_control();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'($urandom);
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 16'sd20480 : -16'sd20480;
    return 16'($signed($urandom_range(0, 40960)) - 20480);
  endfunction

  task automatic add_beat(logic [15:0] ph, logic signed [15:0] mo, logic signed [15:0] mi);
    osc_beat_t b;
    b.phase = ph;
    b.morph = mo;
    b.mix = mi;
    stim_q.push_back(b);
  endtask

  // Input driver: presents queued beats with random gaps and two drain pauses.
  always @(posedge clk) begin : driver
    int        send_gap;
    int        n_now;
    logic      hold;
    osc_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      n_now = in_count;
      if (in_valid && !in_stall) begin
        exp_samples.push_back(shaped_sample(in_phase, in_morph_control, in_mix_control));
        n_now = in_count + 1;
        in_count <= in_count + 1;
      end
      hold = (n_now == PAUSE_A || n_now == PAUSE_B) && (out_count < n_now);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() != 0 && !hold) begin
          beat = stim_q.pop_front();
          in_phase <= beat.phase;
          in_morph_control <= beat.morph;
          in_mix_control <= beat.mix;
          in_valid <= 1'b1;
          if (idle_ok && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall bursts.
  always @(posedge clk) begin : monitor
    int                 stall_left;
    logic signed [15:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        out_count <= out_count + 1;
        if (exp_samples.size() == 0) begin
          $error("out_sample: expected none, actual %0d", out_sample);
          errors++;
        end else begin
          want = exp_samples.pop_front();
          if (out_sample !== want) begin
            $error("out_sample: expected %0d, actual %0d", want, out_sample);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_ok && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no beat on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) quiet++;
      else quiet = 0;
    end
    $display("morphing_oscillator_diode_shaper_tb failed");
    $finish;
  end

  initial begin : main
    for (int i = 0; i < COS_N; i++) cos_lut[i] = cosine_word(i);
    for (int i = 0; i < EXP_N; i++) diode_lut[i] = diode_word(i);

    // Directed beats: field extremes, saturating controls, wave pair boundaries.
    add_beat(16'd0, -16'sd20480, -16'sd20480);
    add_beat(16'd65535, 16'sd20480, 16'sd20480);
    add_beat(16'd32767, 16'sd0, 16'sd0);
    add_beat(16'd32768, 16'sd0, 16'sd0);
    add_beat(16'd16384, -16'sd32768, 16'sd32767);
    add_beat(16'd49152, 16'sd32767, -16'sd32768);
    add_beat(16'd0, 16'sd20481, -16'sd20481);
    add_beat(16'd8192, -16'sd10237, 16'sd0);
    add_beat(16'd24576, -16'sd10238, 16'sd5000);
    add_beat(16'd40000, 16'sd6, 16'sd10240);
    add_beat(16'd57344, 16'sd10248, -16'sd10240);
    add_beat(16'd65535, 16'sd20480, -16'sd20480);
    add_beat(16'd1, -16'sd20480, 16'sd20480);
    add_beat(16'd32768, 16'sd20480, 16'sd20480);
    add_beat(16'd0, -16'sd20480, 16'sd20480);
    add_beat(16'd16383, -16'sd6000, 16'sd12345);
    add_beat(16'hAAAA, 16'sh5555, 16'shAAAA);
    add_beat(16'h5555, 16'shAAAA, 16'sh5555);

    // Random beats, with the phase now and then pinned to a wave edge.
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 15))
        0: add_beat(16'd0, pick_control(), pick_control());
        1: add_beat(16'd32768, pick_control(), pick_control());
        2: add_beat(16'd65535, pick_control(), pick_control());
        default: add_beat(16'($urandom_range(0, 65535)), pick_control(), pick_control());
      endcase
    end
    n_total = stim_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || in_valid || exp_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && exp_samples.size() == 0) begin
      $display("morphing_oscillator_diode_shaper_tb passed");
    end else begin
      $display("morphing_oscillator_diode_shaper_tb failed");
    end
    $finish;
  end

endmodule
